// ----- rtl/f2pcm_pkg.sv -----
// f2pcm_pkg: shared constants, types and functions for the float-to-PCM quantizer.
// Used by f2pcm_dither, f2pcm_datapath and float_to_pcm_dither_quantizer.
`timescale 1ns / 1ps

package f2pcm_pkg;

    // Output format codes
    localparam logic [1:0] FMT_PCM16 = 2'd0;
    localparam logic [1:0] FMT_PCM24 = 2'd1;
    localparam logic [1:0] FMT_FLOAT = 2'd2;

    // Config register indexes
    localparam int         CFG_IDX_W         = 2;
    localparam logic [1:0] CFG_SAMPLE_FORMAT = 2'd0;
    localparam logic [1:0] CFG_DITHER_SEED   = 2'd1;

    // Reset values
    localparam logic [1:0]  FORMAT_RESET = FMT_PCM24;
    localparam logic [31:0] SEED_RESET   = 32'd1;

    // Byte counts per format
    localparam logic [2:0] BYTES_PCM16 = 3'd2;
    localparam logic [2:0] BYTES_PCM24 = 3'd3;
    localparam logic [2:0] BYTES_FLOAT = 3'd4;

    // Fixed point: one full scale is 2^47
    localparam logic [47:0] Q_ONE  = 48'h8000_0000_0000;
    localparam logic [23:0] FULL24 = 24'h7F_FFFF;

    // xorshift32 shift amounts
    localparam int XS_A = 13;
    localparam int XS_B = 17;
    localparam int XS_C = 5;

    typedef struct packed {
        logic load;
        logic advance;
    } dither_ctrl_t;

    function automatic logic [31:0] xs_step(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << XS_A);
        t = t ^ (t >> XS_B);
        t = t ^ (t << XS_C);
        return t;
    endfunction

endpackage

// ----- rtl/f2pcm_dither.sv -----
// f2pcm_dither: xorshift32 state and TPDF dither value (difference of two draws).
// Depends on f2pcm_pkg.
`timescale 1ns / 1ps

module f2pcm_dither (
    input  logic                     clk,
    input  logic                     rst_n,
    input  f2pcm_pkg::dither_ctrl_t  ctrl,
    input  logic [31:0]              seed,
    output logic signed [32:0]       dither
);

    logic [31:0] state_reg;
    logic [31:0] state_next;
    logic [31:0] draw1;
    logic [31:0] draw2;

    assign draw1  = f2pcm_pkg::xs_step(state_reg);
    assign draw2  = f2pcm_pkg::xs_step(draw1);
    assign dither = $signed({1'b0, draw1}) - $signed({1'b0, draw2});

    always_comb
    begin
        state_next = state_reg;
        if (ctrl.load)
        begin
            state_next = seed;
        end
        else if (ctrl.advance)
        begin
            state_next = draw2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= f2pcm_pkg::SEED_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // xorshift is a bijection on nonzero states: it never falls into zero
    a_state_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != 32'd0 && !ctrl.load) |=> (state_reg != 32'd0))
        else $error("dither state collapsed to zero");

endmodule

// ----- rtl/f2pcm_datapath.sv -----
// f2pcm_datapath: input register, two compute stages and output register,
// with a valid/ready chain. Depends on f2pcm_pkg.
`timescale 1ns / 1ps

module f2pcm_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         fmt,
    input  logic signed [32:0] dither,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  logic [31:0]        sample_bits,
    input  logic               last_in,
    output logic               pcm_valid,
    input  logic               pcm_ready,
    output logic [31:0]        packed_bytes,
    output logic [2:0]         byte_count,
    output logic               last_out
);

    localparam logic signed [50:0] SUM_MAX = {3'b000, f2pcm_pkg::Q_ONE};
    localparam logic signed [50:0] SUM_MIN = -SUM_MAX;

    // ---------------- valid / ready chain ----------------
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic v0_next, v1_next, v2_next, v3_next;
    logic rdy0, rdy1, rdy2, rdy3;

    assign rdy3 = !v3_reg || pcm_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;
    assign sample_ready = rdy0;
    assign pcm_valid    = v3_reg;

    assign v0_next = rdy0 ? sample_valid : v0_reg;
    assign v1_next = rdy1 ? v0_reg : v1_reg;
    assign v2_next = rdy2 ? v1_reg : v2_reg;
    assign v3_next = rdy3 ? v2_reg : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // ---------------- stage 0: input register ----------------
    logic [31:0]        bits0_reg;
    logic               last0_reg;
    logic [1:0]         fmt0_reg;
    logic signed [32:0] dith0_reg;

    always_ff @(posedge clk)
    begin
        if (rdy0 && sample_valid)
        begin
            bits0_reg <= sample_bits;
            last0_reg <= last_in;
            fmt0_reg  <= fmt;
            dith0_reg <= dither;
        end
    end

    // ---------------- stage 1: to fixed point, dither, clamp ----------------
    logic [7:0]         ef;
    logic [22:0]        fr;
    logic               is_nan;
    logic [48:0]        fix_mag;
    logic signed [49:0] fix_val;
    logic signed [50:0] sum_raw;
    logic signed [50:0] sum_clamp;
    logic [50:0]        sum_abs;
    logic               neg16_next;
    logic [47:0]        mag16_next;
    logic               neg24_next;
    logic               full24_next;
    logic               zero24_next;
    logic [23:0]        m24_next;
    logic [7:0]         r24;

    assign ef     = bits0_reg[30:23];
    assign fr     = bits0_reg[22:0];
    assign is_nan = (ef == 8'hFF) && (fr != 23'd0);

    always_comb
    begin
        if (ef >= 8'd128)
        begin
            fix_mag = {1'b1, 48'd0};
        end
        else if (ef == 8'd0)
        begin
            fix_mag = 49'd0;
        end
        else
        begin
            fix_mag = {1'b0, 1'b1, fr, 24'd0} >> (8'd127 - ef);
        end
        fix_val = (bits0_reg[31] && !is_nan) ? -$signed({1'b0, fix_mag})
                                             : $signed({1'b0, fix_mag});
        sum_raw = {fix_val[49], fix_val} + {{18{dith0_reg[32]}}, dith0_reg};
        if (sum_raw > SUM_MAX)
        begin
            sum_clamp = SUM_MAX;
        end
        else if (sum_raw < SUM_MIN)
        begin
            sum_clamp = SUM_MIN;
        end
        else
        begin
            sum_clamp = sum_raw;
        end
        neg16_next = sum_clamp[50];
        sum_abs    = neg16_next ? 51'(-sum_clamp) : 51'(sum_clamp);
        mag16_next = sum_abs[47:0];

        // PCM24: magnitude is m * 8388607 * 2^-r, r = 150 - exp (149 for subnormals)
        neg24_next  = bits0_reg[31] && !is_nan;
        full24_next = (ef >= 8'd127);
        m24_next    = (ef == 8'd0) ? {1'b0, fr} : {1'b1, fr};
        r24         = (ef == 8'd0) ? 8'd149 : (8'd150 - ef);
        zero24_next = (r24 >= 8'd48);
    end

    logic [31:0] bits1_reg;
    logic        last1_reg;
    logic [1:0]  fmt1_reg;
    logic        neg16_reg;
    logic [47:0] mag16_reg;
    logic        neg24_1_reg;
    logic        full24_1_reg;
    logic        zero24_1_reg;
    logic [23:0] m24_reg;
    logic [5:0]  r24_1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1 && v0_reg)
        begin
            bits1_reg    <= bits0_reg;
            last1_reg    <= last0_reg;
            fmt1_reg     <= fmt0_reg;
            neg16_reg    <= neg16_next;
            mag16_reg    <= mag16_next;
            neg24_1_reg  <= neg24_next;
            full24_1_reg <= full24_next;
            zero24_1_reg <= zero24_next;
            m24_reg      <= m24_next;
            r24_1_reg    <= r24[5:0];
        end
    end

    // ---------------- stage 2: scale (x*(2^k - 1) as shift and subtract) ----
    logic [62:0] prod16_next;
    logic [46:0] prod24_next;

    assign prod16_next = {mag16_reg, 15'd0} - {15'd0, mag16_reg};
    assign prod24_next = {m24_reg, 23'd0} - {23'd0, m24_reg};

    logic [31:0] bits2_reg;
    logic        last2_reg;
    logic [1:0]  fmt2_reg;
    logic        neg16_2_reg;
    logic [62:0] prod16_reg;
    logic        neg24_2_reg;
    logic        full24_2_reg;
    logic        zero24_2_reg;
    logic [46:0] prod24_reg;
    logic [5:0]  r24_2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            bits2_reg    <= bits1_reg;
            last2_reg    <= last1_reg;
            fmt2_reg     <= fmt1_reg;
            neg16_2_reg  <= neg16_reg;
            prod16_reg   <= prod16_next;
            neg24_2_reg  <= neg24_1_reg;
            full24_2_reg <= full24_1_reg;
            zero24_2_reg <= zero24_1_reg;
            prod24_reg   <= prod24_next;
            r24_2_reg    <= r24_1_reg;
        end
    end

    // ---------------- stage 3: round half-to-even, sign, pack ----------------
    logic [14:0] q16_trunc;
    logic        up16;
    logic [15:0] q16;
    logic [15:0] val16;
    logic [5:0]  rm1;
    logic [46:0] shifted24;
    logic [46:0] mask24;
    logic        up24;
    logic [23:0] q24;
    logic [23:0] val24;
    logic [31:0] packed_next;
    logic [2:0]  count_next;

    always_comb
    begin
        q16_trunc = prod16_reg[61:47];
        up16      = prod16_reg[46] && ((|prod16_reg[45:0]) || q16_trunc[0]);
        q16       = {1'b0, q16_trunc} + {15'd0, up16};
        val16     = neg16_2_reg ? 16'(-q16) : q16;

        rm1       = r24_2_reg - 6'd1;
        shifted24 = prod24_reg >> rm1;
        mask24    = (47'd1 << rm1) - 47'd1;
        up24      = shifted24[0] && ((|(prod24_reg & mask24)) || shifted24[1]);
        if (full24_2_reg)
        begin
            q24 = f2pcm_pkg::FULL24;
        end
        else if (zero24_2_reg)
        begin
            q24 = 24'd0;
        end
        else
        begin
            q24 = shifted24[24:1] + {23'd0, up24};
        end
        val24 = neg24_2_reg ? 24'(-q24) : q24;

        case (fmt2_reg)
            f2pcm_pkg::FMT_PCM16:
            begin
                packed_next = {16'd0, val16};
                count_next  = f2pcm_pkg::BYTES_PCM16;
            end
            f2pcm_pkg::FMT_PCM24:
            begin
                packed_next = {8'd0, val24};
                count_next  = f2pcm_pkg::BYTES_PCM24;
            end
            default:
            begin
                packed_next = bits2_reg;
                count_next  = f2pcm_pkg::BYTES_FLOAT;
            end
        endcase
    end

    logic [31:0] packed_reg;
    logic [2:0]  count_reg;
    logic        last3_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            packed_reg <= packed_next;
            count_reg  <= count_next;
            last3_reg  <= last2_reg;
        end
    end

    assign packed_bytes = packed_reg;
    assign byte_count   = count_reg;
    assign last_out     = last3_reg;

    // ---------------- checks ----------------
    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        pcm_valid |-> (byte_count == f2pcm_pkg::BYTES_PCM16 ||
                       byte_count == f2pcm_pkg::BYTES_PCM24 ||
                       byte_count == f2pcm_pkg::BYTES_FLOAT))
        else $error("illegal byte count");

    a_pcm16_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pcm_valid && byte_count == f2pcm_pkg::BYTES_PCM16) |->
        (packed_bytes[31:16] == 16'd0 && packed_bytes[15:0] != 16'h8000))
        else $error("pcm16 word out of range");

    a_pcm24_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pcm_valid && byte_count == f2pcm_pkg::BYTES_PCM24) |->
        (packed_bytes[31:24] == 8'd0 && packed_bytes[23:0] != 24'h80_0000))
        else $error("pcm24 word out of range");

    a_sample_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (!v0_reg || !v1_reg || !v2_reg || !v3_reg || pcm_ready) |-> sample_ready)
        else $error("input stalled with a free stage");

endmodule

// ----- rtl/float_to_pcm_dither_quantizer.sv -----
// float_to_pcm_dither_quantizer: top level, config registers and handshake glue.
// Depends on f2pcm_pkg, f2pcm_dither and f2pcm_datapath.
`timescale 1ns / 1ps
//
// Usage
//   Sample channel (sample_valid/sample_ready): one IEEE-754 single word per
//   transfer, with last_in tagging the final word of a burst.
//   PCM channel (pcm_valid/pcm_ready): one word per sample, packed_bytes is
//   little-endian with unused high bytes zero, byte_count says 2, 3 or 4.
//   Config port: cfg_we with cfg_index 0 writes sample_format (0 pcm16 with
//   TPDF dither, 1 pcm24, 2 or 3 float passthrough); index 1 writes the
//   xorshift32 seed and loads the dither state at once. Write only while idle.
// Timing
//   Four register stages: input, fixed-point/clamp, scale, round/pack.
//   An accepted word passes through each stage in order to the PCM outputs.
//   Throughput is one word per cycle without stalls; the stage depth sets latency.
// Reset and stalls
//   Reset empties the pipeline, selects pcm24 and sets the dither state to 1.
//   When pcm_ready is low the words in flight close up into empty stages;
//   sample_ready drops only once all four stages hold a word.
//   The dither state steps twice per accepted word, in pcm16 mode only.

module float_to_pcm_dither_quantizer (
    input  logic                              clk,
    input  logic                              rst_n,
    // config
    input  logic                              cfg_we,
    input  logic [f2pcm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                       cfg_data,
    // samples in
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  logic [31:0]                       sample_bits,
    input  logic                              last_in,
    // PCM words out
    output logic                              pcm_valid,
    input  logic                              pcm_ready,
    output logic [31:0]                       packed_bytes,
    output logic [2:0]                        byte_count,
    output logic                              last_out
);

    logic [1:0]              format_reg;
    logic [1:0]              format_next;
    f2pcm_pkg::dither_ctrl_t dith_ctrl;
    logic signed [32:0]      dither;

    // format register
    always_comb
    begin
        format_next = format_reg;
        if (cfg_we && cfg_index == f2pcm_pkg::CFG_SAMPLE_FORMAT)
        begin
            format_next = cfg_data[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= f2pcm_pkg::FORMAT_RESET;
        end
        else
        begin
            format_reg <= format_next;
        end
    end

    // seed write loads the generator; each pcm16 word consumes two draws
    assign dith_ctrl.load    = cfg_we && (cfg_index == f2pcm_pkg::CFG_DITHER_SEED);
    assign dith_ctrl.advance = sample_valid && sample_ready &&
                               (format_reg == f2pcm_pkg::FMT_PCM16);

    f2pcm_dither u_dither (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (dith_ctrl),
        .seed   (cfg_data),
        .dither (dither)
    );

    f2pcm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .fmt          (format_reg),
        .dither       (dither),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_bits  (sample_bits),
        .last_in      (last_in),
        .pcm_valid    (pcm_valid),
        .pcm_ready    (pcm_ready),
        .packed_bytes (packed_bytes),
        .byte_count   (byte_count),
        .last_out     (last_out)
    );

endmodule

// ----- sim/tb_float_to_pcm_dither_quantizer.sv -----
// Testbench for float_to_pcm_dither_quantizer: float samples in, packed PCM words out.
// Checks every word against a local bit-exact quantizer model (pcm16 dither, pcm24, float).
// Depends on f2pcm_pkg and the float_to_pcm_dither_quantizer RTL.
`timescale 1ns / 1ps

module tb_float_to_pcm_dither_quantizer;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int LATENCY_PAD    = 6;     // leave a little slack for the pipe to settle
    localparam int HOLD_CYCLES    = 80;    // long receiver stall, fills all four stages
    localparam int STALL_ITEMS    = 30;
    localparam int RANDOM_PHASES  = 12;
    localparam int STEADY_PHASE   = 4;     // phase with no idling on either side
    localparam int IDLE_PERCENT   = 35;
    localparam int MAX_GAP        = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 30;

    // format code 3 is unused and behaves as float passthrough
    localparam logic [1:0] FMT_SPARE       = 2'd3;
    // register indexes past the seed are ignored
    localparam logic [1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_IDX_SPARE_B = 2'd3;

    // fixed point with 47 fraction bits: full scale and the saturation value for |x| >= 2
    localparam longint FIXED_ONE = 64'sh0000_8000_0000_0000;
    localparam longint FIXED_SAT = 64'sh0001_0000_0000_0000;
    localparam int     FIXED_FRAC = 47;
    localparam logic [63:0] PCM16_SCALE = 64'd32767;
    localparam logic [63:0] PCM24_SCALE = 64'd8388607;

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  count;
        logic        last;
    } pcm_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [f2pcm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 sample_valid;
    logic                 sample_ready;
    logic [31:0]          sample_bits;
    logic                 last_in;
    logic                 pcm_valid;
    logic                 pcm_ready;
    logic [31:0]          packed_bytes;
    logic [2:0]           byte_count;
    logic                 last_out;

    // quantizer model state, kept in step with what the block has accepted
    logic [1:0]  model_format;
    logic [31:0] model_dither;

    pcm_word_t   expected_words[$];
    pcm_word_t   want_word;
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;

    // idling controls shared between the test tasks and the receiver
    logic        sender_steady = 1'b0;
    logic        sink_steady   = 1'b0;
    logic        hold_request  = 1'b0;

    float_to_pcm_dither_quantizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_bits  (sample_bits),
        .last_in      (last_in),
        .pcm_valid    (pcm_valid),
        .pcm_ready    (pcm_ready),
        .packed_bytes (packed_bytes),
        .byte_count   (byte_count),
        .last_out     (last_out)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Quantizer model
    // ------------------------------------------------------------------

    // xorshift32 with shifts 13, 17, 5
    function automatic logic [31:0] xorshift_next(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    // shift right by r, round half to even; shifts of 64 or more give zero
    function automatic logic [63:0] round_half_even(input logic [63:0] mag, input int r);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        if (r == 0)
            return mag;
        if (r >= 64)
            return 64'd0;
        q    = mag >> r;
        rem  = mag & ((64'd1 << r) - 64'd1);
        half = 64'd1 << (r - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 64'd1;
        return q;
    endfunction

    // float bits to signed Q.47, magnitude truncated; |x| >= 2, inf and NaN saturate
    function automatic longint float_to_fixed(input logic [31:0] b);
        logic [7:0]  e;
        logic [22:0] f;
        logic [63:0] m;
        logic [63:0] mag;
        int          sh;
        e = b[30:23];
        f = b[22:0];
        if (e == 8'hFF && f != 23'd0)
            return FIXED_SAT;
        if (e >= 8'd128)
            return b[31] ? -FIXED_SAT : FIXED_SAT;
        if (e == 8'd0)
            return 64'sd0;
        m  = {40'd0, 1'b1, f};
        sh = int'(e) - (150 - FIXED_FRAC);
        if (sh >= 0)
            mag = m << sh;
        else if (-sh < 32)
            mag = m >> (-sh);
        else
            mag = 64'd0;
        return b[31] ? -longint'(mag) : longint'(mag);
    endfunction

    // pcm16: TPDF dither from two draws, clamp, scale, round; steps the dither state twice
    function automatic logic [31:0] quantize_pcm16(input logic [31:0] b);
        logic [31:0] draw_a;
        logic [31:0] draw_b;
        longint      sum;
        logic [63:0] mag;
        logic [63:0] q;
        draw_a       = xorshift_next(model_dither);
        draw_b       = xorshift_next(draw_a);
        model_dither = draw_b;
        sum = float_to_fixed(b) + (longint'({32'd0, draw_a}) - longint'({32'd0, draw_b}));
        if (sum > FIXED_ONE)
            sum = FIXED_ONE;
        if (sum < -FIXED_ONE)
            sum = -FIXED_ONE;
        mag = (sum < 0) ? -sum : sum;
        q   = round_half_even(mag * PCM16_SCALE, FIXED_FRAC);
        if (sum < 0)
            q = -q;
        return {16'd0, q[15:0]};
    endfunction

    // pcm24: exact product mantissa * 8388607 * 2^(exp-150), rounded half to even
    function automatic logic [31:0] quantize_pcm24(input logic [31:0] b);
        logic [7:0]  e;
        logic [22:0] f;
        logic [63:0] m;
        logic [63:0] q;
        int          r;
        e = b[30:23];
        f = b[22:0];
        if (e == 8'hFF && f != 23'd0)
            return {8'd0, f2pcm_pkg::FULL24};   // NaN goes to +full scale whatever its sign
        if (e >= 8'd127)
        begin
            q = {40'd0, f2pcm_pkg::FULL24};
        end
        else
        begin
            if (e == 8'd0)
            begin
                m = {41'd0, f};
                r = 149;
            end
            else
            begin
                m = {40'd0, 1'b1, f};
                r = 150 - int'(e);
            end
            q = round_half_even(m * PCM24_SCALE, r);
        end
        if (b[31])
            q = -q;
        return {8'd0, q[23:0]};
    endfunction

    function automatic pcm_word_t predict_word(input logic [31:0] b, input logic last);
        pcm_word_t w;
        w.last = last;
        case (model_format)
            f2pcm_pkg::FMT_PCM16:
            begin
                w.data  = quantize_pcm16(b);
                w.count = f2pcm_pkg::BYTES_PCM16;
            end
            f2pcm_pkg::FMT_PCM24:
            begin
                w.data  = quantize_pcm24(b);
                w.count = f2pcm_pkg::BYTES_PCM24;
            end
            default:
            begin
                w.data  = b;
                w.count = f2pcm_pkg::BYTES_FLOAT;
            end
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly in-range audio, with a share of near/over full scale, tiny values,
    // inf/NaN/zero and raw bit patterns.
    function automatic logic [31:0] random_sample();
        logic        sign;
        logic [7:0]  e;
        logic [22:0] f;
        sign = 1'($urandom_range(1));
        f    = 23'($urandom);
        case ($urandom_range(9))
            0, 1, 2, 3: e = 8'($urandom_range(126, 96));
            4:          e = 8'($urandom_range(127, 126));
            5:          e = 8'($urandom_range(134, 127));
            6:          e = 8'($urandom_range(40, 0));
            7:
            begin
                e = 8'hFF;
                if ($urandom_range(1) == 0)
                    f = 23'd0;
            end
            8:
            begin
                e = 8'd0;
                f = 23'd0;
            end
            default:    return $urandom;
        endcase
        return {sign, e, f};
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t ns  mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Offer one word and block until it is taken. Called at a rising edge;
    // returns at the edge that accepted the word, with valid still high.
    task automatic push_sample(input logic [31:0] bits, input logic last);
        int gap;
        gap = 0;
        while (!sender_steady && gap < MAX_GAP && $urandom_range(99) < IDLE_PERCENT)
            gap++;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_bits  <= bits;
        last_in      <= last;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        expected_words.push_back(predict_word(bits, last));
    endtask

    // Stop sending and wait for every outstanding word, then let the pipe settle.
    task automatic wait_drained();
        sample_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    // cfg_we is held low after the write before returning: never lowered and raised in one step.
    task automatic write_reg(input logic [f2pcm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            f2pcm_pkg::CFG_SAMPLE_FORMAT: model_format = data[1:0];
            f2pcm_pkg::CFG_DITHER_SEED:   model_dither = data;
            default:                      ;
        endcase
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero, +-1, 0.5 (a pcm24 rounding tie), +-inf, negative NaN and a negative
    // subnormal, first under the reset format and reset dither state, then in
    // pcm16 and float; format code 3 gets a single -pi word.
    task automatic test_special_values();
        logic [31:0] specials [8];
        specials = '{32'h0000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3F00_0000,
                     32'h7F80_0000, 32'hFF80_0000, 32'hFFC0_0001, 32'h807F_FFFF};
        foreach (specials[i])
            push_sample(specials[i], 1'(i % 2));
        wait_drained();
        write_reg(f2pcm_pkg::CFG_SAMPLE_FORMAT, {30'd0, f2pcm_pkg::FMT_PCM16});
        foreach (specials[i])
            push_sample(specials[i], 1'((i + 1) % 2));
        wait_drained();
        write_reg(f2pcm_pkg::CFG_SAMPLE_FORMAT, {30'd0, f2pcm_pkg::FMT_FLOAT});
        foreach (specials[i])
            push_sample(specials[i], 1'(i % 2));
        wait_drained();
        write_reg(f2pcm_pkg::CFG_SAMPLE_FORMAT, {30'd0, FMT_SPARE});
        push_sample(32'hC049_0FDB, 1'b1);
        wait_drained();
    endtask

    // Seed extremes, the zero seed, a seed loaded outside pcm16, and writes to
    // unused indexes that must leave both registers alone.
    task automatic test_register_writes();
        write_reg(f2pcm_pkg::CFG_SAMPLE_FORMAT, {30'd0, f2pcm_pkg::FMT_PCM16});
        write_reg(f2pcm_pkg::CFG_DITHER_SEED, 32'hFFFF_FFFF);
        repeat (3) push_sample(random_sample(), 1'b0);
        push_sample(32'h3800_0000, 1'b1);              // about one pcm16 LSB
        wait_drained();
        // zero seed: xorshift stays at zero, so no dither at all
        write_reg(f2pcm_pkg::CFG_DITHER_SEED, 32'd0);
        push_sample(32'h3800_0000, 1'b0);
        push_sample(32'hB800_0000, 1'b1);
        wait_drained();
        write_reg(f2pcm_pkg::CFG_SAMPLE_FORMAT, {30'd0, f2pcm_pkg::FMT_PCM24});
        write_reg(f2pcm_pkg::CFG_DITHER_SEED, f2pcm_pkg::SEED_RESET);
        write_reg(CFG_IDX_SPARE_A, 32'hFFFF_FFFF);
        write_reg(CFG_IDX_SPARE_B, {30'd0, f2pcm_pkg::FMT_FLOAT});
        push_sample(32'h3E80_0001, 1'b0);
        push_sample(32'hBE80_0001, 1'b1);
        wait_drained();
        write_reg(f2pcm_pkg::CFG_SAMPLE_FORMAT, {30'd0, f2pcm_pkg::FMT_PCM16});
        push_sample(32'h3E80_0001, 1'b0);
        push_sample(32'hBE80_0001, 1'b1);
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering back to back: the
    // pipe fills and sample_ready has to drop. Then the sender waits for all.
    task automatic test_output_stall();
        write_reg(f2pcm_pkg::CFG_DITHER_SEED, $urandom | 32'd1);
        hold_request  = 1'b1;
        sender_steady = 1'b1;
        repeat (STALL_ITEMS) push_sample(random_sample(), 1'($urandom_range(1)));
        sender_steady = 1'b0;
        wait_drained();
    endtask

    // Phases of random samples, cycling through all four format codes with
    // fresh seeds now and then; one phase runs with no idling anywhere.
    task automatic test_random_stream();
        int          n;
        logic [1:0]  fmt;
        logic [31:0] seed;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            fmt = 2'(phase % 4);
            write_reg(f2pcm_pkg::CFG_SAMPLE_FORMAT, {30'($urandom), fmt});
            if ($urandom_range(2) != 0)
            begin
                seed = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom;
                if (seed == 32'd0)
                    seed = f2pcm_pkg::SEED_RESET;
                write_reg(f2pcm_pkg::CFG_DITHER_SEED, seed);
            end
            sender_steady = (phase == STEADY_PHASE);
            sink_steady   = (phase == STEADY_PHASE);
            n = $urandom_range(220, 100);
            repeat (n) push_sample(random_sample(), 1'($urandom_range(1)));
        end
        sender_steady = 1'b0;
        sink_steady   = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, or a long hold-off when a test asks for one
    // ------------------------------------------------------------------
    initial
    begin
        pcm_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                pcm_ready   <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pcm_ready <= sink_steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------
    // Output checker: each accepted word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && pcm_valid && pcm_ready)
        begin
            if (expected_words.size() == 0)
            begin
                report_mismatch($sformatf("word %h arrived with nothing expected",
                                          packed_bytes));
            end
            else
            begin
                want_word = expected_words.pop_front();
                if (packed_bytes !== want_word.data)
                    report_mismatch($sformatf("packed_bytes got %h want %h",
                                              packed_bytes, want_word.data));
                if (byte_count !== want_word.count)
                    report_mismatch($sformatf("byte_count got %0d want %0d",
                                              byte_count, want_word.count));
                if (last_out !== want_word.last)
                    report_mismatch($sformatf("last_out got %b want %b",
                                              last_out, want_word.last));
            end
        end
    end

    // Watchdog: too long without any word moving on either channel.
    always @(posedge clk)
    begin
        if ((sample_valid && sample_ready) || (pcm_valid && pcm_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d words outstanding",
                     quiet_cycles, expected_words.size());
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = f2pcm_pkg::CFG_SAMPLE_FORMAT;
        cfg_data     = 32'd0;
        sample_valid = 1'b0;
        sample_bits  = 32'd0;
        last_in      = 1'b0;
        model_format = f2pcm_pkg::FORMAT_RESET;
        model_dither = f2pcm_pkg::SEED_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_values();
        test_register_writes();
        test_output_stall();
        test_random_stream();
        wait_drained();

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
